### sv/mvic_pkg.sv
// Package for the mesh vertex index compactor.
// Holds field widths, stream packing constants and the control state type.
// No dependencies.
package mvic_pkg;

	// field widths
	localparam int VIDX_W  = 16;
	localparam int NEWI_W  = 16;
	localparam int COUNT_W = 17;

	// largest index space that a 16-bit vertex index can address
	localparam int IDX_SPACE = 65536;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 56;
	localparam int M_PAD_W   = M_TDATA_W - NEWI_W - VIDX_W - COUNT_W;

	// function codes on the input tuser
	localparam logic FUNC_REMAP = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CHECK
	} mvic_state_t;

endpackage

### sv/mvic_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and held while rd_en is low. No dependencies.
module mvic_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/mesh_vertex_index_compactor.sv
// Top level of the mesh vertex index compactor.
// Depends on mvic_pkg and mvic_ram (remap table and its back-reference table).
//
// Renumbers the vertex indices of a mesh densely in order of first use. Each
// input beat with tuser = 0 carries one old index and returns its new index,
// a first-use flag (copy point source_index to slot new_index) and the running
// count of used vertices; tuser = 1 starts a new mesh and returns all zeros.
// Indices at or above MAX_VERTICES are echoed with new_index 0 and are not
// counted. The seen marks are kept as a sparse set: remap[old] = new and
// back[new] = old, and an old index counts as seen only when
// remap[old] < count and back[remap[old]] == old. Starting a mesh therefore
// only zeroes the count: there is no clearing pass after reset or per mesh,
// and the block takes beats right out of reset. Each beat passes through
// ST_IDLE (accept, read the remap entry), ST_LOOK (read the back reference that
// entry points at) and ST_CHECK (write back); a new beat is taken only in ST_IDLE,
// and a stalled result output holds the block in ST_CHECK until the output register frees.
module mesh_vertex_index_compactor #(
	parameter int unsigned MAX_VERTICES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mvic_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] vertex_index
	input  logic                           s_tuser,   // [0] func
	// master side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] new_index, [31:16] source_index, [48:32] used_count, [55:49] zero
	output logic [mvic_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser    // [0] first_use
);

	import mvic_pkg::*;

	// table depth: never more than a 16-bit index can reach
	localparam int DEPTH = (MAX_VERTICES < IDX_SPACE) ? int'(MAX_VERTICES) : IDX_SPACE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [31:0] MAX_V = 32'(MAX_VERTICES);

	mvic_state_t state_q, state_nxt;

	// item under work
	logic              func_q;
	logic [VIDX_W-1:0] idx_q;
	logic [CW-1:0]     count_q;

	// memory ports
	logic          remap_re, back_re, mem_we;
	logic [AW-1:0] remap_rdata, back_rdata;

	// result of the current item
	logic              hit, in_range, load_out;
	logic [NEWI_W-1:0] res_new;
	logic              res_first;
	logic [VIDX_W-1:0] res_src;
	logic [CW-1:0]     cnt_nxt;

	// output register
	logic               out_valid_q;
	logic [NEWI_W-1:0]  out_new_q;
	logic               out_first_q;
	logic [VIDX_W-1:0]  out_src_q;
	logic [COUNT_W-1:0] out_cnt_q;

	// remap table: old index -> new index
	mvic_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_remap (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (idx_q[AW-1:0]),
		.wr_data (count_q[AW-1:0]),
		.rd_en   (remap_re),
		.rd_addr (s_tdata[AW-1:0]),
		.rd_data (remap_rdata)
	);

	// back-reference table: new index -> old index
	mvic_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_back (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (idx_q[AW-1:0]),
		.rd_en   (back_re),
		.rd_addr (remap_rdata),
		.rd_data (back_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequencer: accept, read remap, read back reference, write back
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		remap_re  = 1'b0;
		back_re   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					remap_re  = 1'b1;
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				back_re   = 1'b1;
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (!out_valid_q || m_tready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// seen test; an unwritten entry fails at least one compare and reads as unseen
	always_comb begin
		if ((CW'(remap_rdata) < count_q) && (back_rdata == idx_q[AW-1:0])) begin
			hit = 1'b1;
		end else begin
			hit = 1'b0;
		end
	end

	assign in_range = ({16'd0, idx_q} < MAX_V);

	// result and count update
	always_comb begin
		res_new   = '0;
		res_first = 1'b0;
		res_src   = '0;
		cnt_nxt   = count_q;
		if (func_q == FUNC_START) begin
			cnt_nxt = '0;
		end else begin
			res_src = idx_q;
			if (in_range) begin
				if (hit) begin
					res_new = NEWI_W'(remap_rdata);
				end else begin
					res_new   = NEWI_W'(count_q[AW-1:0]);
					res_first = 1'b1;
					cnt_nxt   = count_q + CW'(1);
				end
			end
		end
	end

	assign mem_we = load_out && res_first;

	// item capture and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load_out) begin
			count_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			idx_q  <= s_tdata[VIDX_W-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_new_q   <= res_new;
			out_first_q <= res_first;
			out_src_q   <= res_src;
			out_cnt_q   <= COUNT_W'(cnt_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_cnt_q, out_src_q, out_new_q};
	assign m_tuser  = out_first_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("used count exceeds table depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < CW'(DEPTH)))
		else $error("new index assigned with table full");

	a_first_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q == $past(count_q) + CW'(1)))
		else $error("first use did not advance the count");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_LOOK) && !s_tready)
		else $error("accepted beat did not start a table lookup");

endmodule

### verif/index_remap_checker.sv
// Checker for the mesh vertex index compactor: watches both stream channels,
// predicts each result beat and compares it field by field.
// Depends on mvic_pkg for field widths and function codes.
`timescale 1ns / 1ps

module index_remap_checker #(
	parameter int unsigned MAX_VERTICES = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [mvic_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] vertex_index
	input  logic                           s_tuser,   // [0] func
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] new_index, [31:16] source_index, [48:32] used_count, [55:49] zero
	input  logic [mvic_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           m_tuser,   // [0] first_use
	output int                             mismatches,
	output int                             outstanding
);
	import mvic_pkg::*;

	typedef struct packed {
		logic [NEWI_W-1:0]  new_index;
		logic               first_use;
		logic [VIDX_W-1:0]  source_index;
		logic [COUNT_W-1:0] used_count;
	} remap_result_t;

	// seen marks kept as a mesh number per old index: a start just bumps it
	int unsigned        mesh_epoch = 1;
	int unsigned        seen_epoch [IDX_SPACE];
	logic [NEWI_W-1:0]  dense_slot [IDX_SPACE];
	logic [COUNT_W-1:0] vertex_count = '0;
	remap_result_t      remaps_due [$];

	// renumber one old index, or start a new mesh
	function automatic remap_result_t assign_dense_index(input logic func,
			input logic [VIDX_W-1:0] vidx);
		remap_result_t r;
		r = '0;
		if (func == FUNC_START) begin
			mesh_epoch++;
			vertex_count = '0;
		end else begin
			r.source_index = vidx;
			if (vidx < MAX_VERTICES) begin
				if (seen_epoch[vidx] == mesh_epoch) begin
					r.new_index = dense_slot[vidx];
				end else begin
					r.new_index      = vertex_count[NEWI_W-1:0];
					r.first_use      = 1'b1;
					dense_slot[vidx] = vertex_count[NEWI_W-1:0];
					seen_epoch[vidx] = mesh_epoch;
					vertex_count     = vertex_count + 1'b1;
				end
			end
		end
		r.used_count = vertex_count;
		return r;
	endfunction

	// sample both channels at the edge; inputs change only after it
	always @(posedge clk or negedge arst_n) begin : watch
		remap_result_t got;
		remap_result_t want;
		if (!arst_n) begin
			mesh_epoch   = mesh_epoch + 1;
			vertex_count = '0;
			mismatches   = 0;
			remaps_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				remaps_due = {remaps_due,
					assign_dense_index(s_tuser, s_tdata[VIDX_W-1:0])};
			if (m_tvalid && m_tready) begin
				got.new_index    = m_tdata[NEWI_W-1:0];
				got.source_index = m_tdata[NEWI_W +: VIDX_W];
				got.used_count   = m_tdata[NEWI_W+VIDX_W +: COUNT_W];
				got.first_use    = m_tuser;
				if (remaps_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat: new %0d first %0b src %0d count %0d",
						$realtime, got.new_index, got.first_use, got.source_index,
						got.used_count);
				end else begin
					want = remaps_due.pop_front();
					if (got.new_index !== want.new_index || got.first_use !== want.first_use
							|| got.source_index !== want.source_index
							|| got.used_count !== want.used_count) begin
						mismatches++;
						$display("%0t: mismatch: expected new %0d first %0b src %0d count %0d",
							$realtime, want.new_index, want.first_use, want.source_index,
							want.used_count);
						$display("%0t:           actual   new %0d first %0b src %0d count %0d",
							$realtime, got.new_index, got.first_use, got.source_index,
							got.used_count);
					end
				end
			end
		end
		outstanding = remaps_due.size();
	end

endmodule

### verif/testbench.sv
// Top of the mesh vertex index compactor testbench: clock, reset, stimulus,
// result-side stalls and the verdict. Depends on mvic_pkg, the block and
// index_remap_checker.
`timescale 1ns / 1ps

module testbench;
	import mvic_pkg::*;

	localparam int unsigned MAX_VERTICES = 65536;
	localparam int          RANDOM_BEATS = 1760;
	localparam int          CALM_TAIL    = 250;
	localparam int          SWEEP_LEN    = 64;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = FUNC_REMAP;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	int   mismatches;
	int   outstanding;
	int   beats_sent = 0;
	int   stall_left = 0;
	logic calm       = 1'b0;   // no idling on either side while set

	always #6 clk = ~clk;

	mesh_vertex_index_compactor #(
		.MAX_VERTICES(MAX_VERTICES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	index_remap_checker #(
		.MAX_VERTICES(MAX_VERTICES)
	) remap_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// random result-side stalls; no new one starts while calm is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one input beat; called right after a rising edge, returns right after
	// the edge that took the beat
	task automatic send_beat(input logic func, input logic [VIDX_W-1:0] vidx);
		logic took;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= vidx;
		// ready is settled by the falling edge, inputs only move at rising ones
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		beats_sent++;
	endtask

	initial begin
		logic [VIDX_W-1:0] pool_base;
		logic [VIDX_W-1:0] vidx;
		int                pool_size;
		int                run_len;
		int                pick;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, repeats, restarts with junk data
		send_beat(FUNC_START, 16'hFFFF);
		send_beat(FUNC_REMAP, 16'h0000);
		send_beat(FUNC_REMAP, 16'h0000);
		send_beat(FUNC_REMAP, 16'hFFFF);
		send_beat(FUNC_REMAP, 16'hFFFF);
		send_beat(FUNC_REMAP, 16'hAAAA);
		send_beat(FUNC_REMAP, 16'h5555);
		send_beat(FUNC_REMAP, 16'h0001);
		send_beat(FUNC_REMAP, 16'h8000);
		send_beat(FUNC_REMAP, 16'hAAAA);
		send_beat(FUNC_REMAP, 16'h0000);
		send_beat(FUNC_START, 16'h0000);
		send_beat(FUNC_REMAP, 16'h8000);
		send_beat(FUNC_REMAP, 16'h8000);
		send_beat(FUNC_REMAP, 16'h7FFF);
		send_beat(FUNC_START, 16'h1234);
		send_beat(FUNC_REMAP, 16'h1234);
		send_beat(FUNC_REMAP, 16'hFFFF);

		// a run of distinct indices in scrambled order, back to back
		calm = 1'b1;
		send_beat(FUNC_START, 16'h0F0F);
		for (int i = 0; i < SWEEP_LEN; i++)
			send_beat(FUNC_REMAP, 16'(i * 40503 + 16'h3C5A));
		for (int i = 0; i < 8; i++)
			send_beat(FUNC_REMAP, 16'($urandom));
		send_beat(FUNC_REMAP, 16'h0000);
		send_beat(FUNC_REMAP, 16'hFFFF);
		calm = 1'b0;

		// random meshes: corners mostly from a small pool of nearby indices,
		// some strays and some restarts in the middle of a mesh
		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) != 0)
				send_beat(FUNC_START, 16'($urandom));
			pool_base = 16'($urandom);
			pool_size = $urandom_range(2, 48);
			run_len   = $urandom_range(8, 80);
			for (int k = 0; k < run_len && beats_sent < RANDOM_BEATS; k++) begin
				if (beats_sent >= RANDOM_BEATS - CALM_TAIL)
					calm = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					vidx = pool_base + 16'($urandom_range(0, pool_size - 1));
					send_beat(FUNC_REMAP, vidx);
				end else if (pick < 96) begin
					send_beat(FUNC_REMAP, 16'($urandom));
				end else begin
					send_beat(FUNC_START, 16'($urandom));
				end
			end
		end
		s_tvalid <= 1'b0;

		// drain, then wait a little longer for anything stray
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#15ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
